[hdl/signed_radix_to_ascii_assert.svh]
// Assertion helpers for the RTL. Both expect signals named clk and rst in scope.
`ifndef SIGNED_RADIX_TO_ASCII_ASSERT_SVH
`define SIGNED_RADIX_TO_ASCII_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRTA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/srta_pkg.sv]
package srta_pkg;

  localparam int VALUE_W    = 64;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_DIGITS = 64;
  localparam int MAX_RADIX  = 16;
  localparam int DIGIT_AW   = $clog2(MAX_DIGITS);
  localparam int BIT_CNT_W  = $clog2(VALUE_W);

  localparam logic [RADIX_W-1:0]   RADIX_RESET = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]    MINUS_CHAR  = 8'h2D;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_HIGH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_ADDR,
    ST_DATA
  } state_t;

  // Status from the digit generator to the sequencer.
  typedef struct packed {
    logic               strobe;
    logic               done;
    logic [DIGIT_W-1:0] digit;
  } digit_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [VALUE_W-1:0] chars_low,
                                                   input logic [VALUE_W-1:0] chars_high,
                                                   input logic [DIGIT_W-1:0] d);
    logic [VALUE_W-1:0] word;
    word = d[DIGIT_W-1] ? chars_high : chars_low;
    return word[{d[DIGIT_W-2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

[hdl/srta_in_if.sv]
interface srta_in_if
  import srta_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

[hdl/srta_out_if.sv]
interface srta_out_if
  import srta_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              is_last;
  logic [CNT_W-1:0]  char_count;

  modport source (output valid, output character, output is_last, output char_count,
                  input ready);
  modport sink (input valid, input character, input is_last, input char_count,
                output ready);
endinterface

[hdl/srta_cfg_if.sv]
interface srta_cfg_if
  import srta_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VALUE_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/signed_radix_to_ascii.sv]
// Channel  Role    Payload                          Transfer when
// din      sink    value (64, signed)               din.valid && din.ready
// dout     source  character, is_last, char_count   dout.valid && dout.ready
// cfg      sink    index (2), data (64)             cfg.valid && cfg.ready
//
// Each digit takes a full pass of the bit-serial divider. For a number of D digits
// (at most 63) the sign, if any, is loaded once all digits are divided, and the first
// digit follows it. Output then takes an address state and a data state per digit,
// limited by the registered read of the digit store. rst is synchronous; no clearing
// pass is needed. A stalled dout holds the character register and the sequencer; din
// is taken again once the last character is in the output register.
`include "signed_radix_to_ascii_assert.svh"

module signed_radix_to_ascii
  import srta_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  srta_in_if.sink    din,
  srta_out_if.source dout,
  srta_cfg_if.sink   cfg
);

  localparam logic [VALUE_W-1:0] MIN_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] MAX_MAG   = {1'b0, {(VALUE_W-1){1'b1}}};

  logic [RADIX_W-1:0] radix;
  logic [VALUE_W-1:0] digit_chars_low;
  logic [VALUE_W-1:0] digit_chars_high;
  logic [RADIX_W-1:0] eff_radix;

  state_t             state;
  state_t             state_next;
  logic               neg;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   limit;
  logic [VALUE_W-1:0] magnitude;
  digit_status_t      dstat;

  logic               div_start;
  logic               mem_we;
  logic               load_sign;
  logic               load_digit;
  logic               slot_free;

  logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data;
  logic [CNT_W-1:0]   rd_index;

  logic               out_valid;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;
  logic [CNT_W-1:0]   out_count;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix            <= RADIX_RESET;
      digit_chars_low  <= '0;
      digit_chars_high <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_RADIX:       radix            <= cfg.data[RADIX_W-1:0];
        REG_DIGITS_LOW:  digit_chars_low  <= cfg.data;
        REG_DIGITS_HIGH: digit_chars_high <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (radix < RADIX_W'(2)) begin
      eff_radix = RADIX_W'(2);
    end else if (radix > RADIX_W'(MAX_RADIX)) begin
      eff_radix = RADIX_W'(MAX_RADIX);
    end else begin
      eff_radix = radix;
    end
  end

  // The most negative value is clamped to its neighbour before negation.
  always_comb begin
    priority if (din.value == MIN_VALUE) begin
      magnitude = MAX_MAG;
    end else if (din.value[VALUE_W-1]) begin
      magnitude = ~din.value + 1'b1;
    end else begin
      magnitude = din.value;
    end
  end

  srta_digit_gen u_digit_gen (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (magnitude),
    .radix    (eff_radix),
    .status   (dstat)
  );

  assign slot_free = !out_valid || dout.ready;
  assign limit     = CNT_W'(MAX_DIGITS) - CNT_W'(neg);
  assign rd_index  = k - 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (din.valid) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (dstat.strobe && dstat.done) state_next = ST_SIGN;
      end
      ST_SIGN: begin
        if (!neg || slot_free) state_next = ST_ADDR;
      end
      ST_ADDR: begin
        state_next = ST_DATA;
      end
      ST_DATA: begin
        if (slot_free) state_next = (k == CNT_W'(1)) ? ST_IDLE : ST_ADDR;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    din.ready  = 1'b0;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        din.ready = 1'b1;
        div_start = din.valid;
      end
      ST_DIV: begin
        // Digits beyond the limit are dropped, keeping the least significant.
        mem_we = dstat.strobe && (k < limit);
      end
      ST_SIGN: begin
        load_sign = neg && slot_free;
      end
      ST_ADDR: ;
      ST_DATA: begin
        load_digit = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      neg   <= 1'b0;
      k     <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (div_start) begin
        neg   <= din.value[VALUE_W-1];
        k     <= '0;
        count <= '0;
      end else if (mem_we) begin
        k <= k + 1'b1;
      end else if (load_sign) begin
        count <= count + 1'b1;
      end else if (load_digit) begin
        k     <= k - 1'b1;
        count <= count + 1'b1;
      end
    end
  end

  // Digit store, least significant digit at entry zero.
  always_ff @(posedge clk) begin
    if (mem_we) digit_store[k[DIGIT_AW-1:0]] <= dstat.digit;
    rd_data <= digit_store[rd_index[DIGIT_AW-1:0]];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_sign || load_digit) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_sign) begin
      out_char  <= MINUS_CHAR;
      out_last  <= 1'b0;
      out_count <= count + 1'b1;
    end else if (load_digit) begin
      out_char  <= digit_char(digit_chars_low, digit_chars_high, rd_data);
      out_last  <= (k == CNT_W'(1));
      out_count <= count + 1'b1;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.character  = out_char;
  assign dout.is_last    = out_last;
  assign dout.char_count = out_count;

  `SRTA_ASSERT_SAME(a_strobe_in_div, dstat.strobe, state == ST_DIV, "digit outside division")
  `SRTA_ASSERT_NEXT(a_sign_first, load_sign, out_valid && out_count == CNT_W'(1), "sign not first")
  `SRTA_ASSERT_SAME(a_data_has_digit, state == ST_DATA, k != '0, "read with no digit left")
  `SRTA_ASSERT_SAME(a_store_bound, mem_we, k < CNT_W'(MAX_DIGITS), "digit store overrun")

endmodule

[hdl/srta_digit_gen.sv]
// Bit-serial restoring division: one quotient bit per cycle while busy, and a digit is
// ready once all VALUE_W dividend bits are shifted in. Divisions repeat on the quotient until it reaches zero.
module srta_digit_gen
  import srta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [VALUE_W-1:0]   dividend,
  input  logic [RADIX_W-1:0]   radix,
  output digit_status_t        status
);

  localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_W - 1);

  logic                 busy;
  logic [VALUE_W-1:0]   mag;
  logic [DIGIT_W-1:0]   rem;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 q_nz;
  logic [RADIX_W-1:0]   divisor;

  logic [RADIX_W-1:0]   trial;
  logic                 ge;
  logic [RADIX_W-1:0]   diff;
  logic [DIGIT_W-1:0]   rem_next;
  logic                 q_nz_next;
  logic                 digit_end;

  always_comb begin
    trial     = {rem, mag[VALUE_W-1]};
    ge        = (trial >= divisor);
    diff      = trial - divisor;
    rem_next  = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    q_nz_next = q_nz | ge;
    digit_end = busy && (bit_cnt == BIT_LAST);
  end

  assign status.strobe = digit_end;
  assign status.done   = !q_nz_next;
  assign status.digit  = rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
      rem     <= '0;
      q_nz    <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      bit_cnt <= '0;
      rem     <= '0;
      q_nz    <= 1'b0;
    end else if (busy) begin
      bit_cnt <= bit_cnt + 1'b1;
      if (digit_end) begin
        // The quotient now sits in mag; divide it again unless it is zero.
        rem  <= '0;
        q_nz <= 1'b0;
        busy <= q_nz_next;
      end else begin
        rem  <= rem_next;
        q_nz <= q_nz_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag     <= dividend;
      divisor <= radix;
    end else if (busy) begin
      mag <= {mag[VALUE_W-2:0], ge};
    end
  end

endmodule

[tb/tb_signed_radix_to_ascii.sv]
`timescale 1ns / 100ps

module tb_signed_radix_to_ascii;
  import srta_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [VALUE_W-1:0]   MIN_VALUE  = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0]   MAX_VALUE  = {1'b0, {(VALUE_W-1){1'b1}}};
  // Byte i of each word is the character for digit i (or 8+i).
  localparam logic [VALUE_W-1:0]   ASCII_LOW  = "76543210";
  localparam logic [VALUE_W-1:0]   ASCII_HIGH = "FEDCBA98";

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              is_last;
    logic [CNT_W-1:0]  char_count;
  } text_char_t;

  logic clk;
  logic rst;

  srta_in_if  din_if ();
  srta_out_if dout_if ();
  srta_cfg_if cfg_if ();

  signed_radix_to_ascii uut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if),
    .cfg  (cfg_if)
  );

  // Shadow copies of the configuration registers.
  logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
  logic [VALUE_W-1:0] chars_low = '0;
  logic [VALUE_W-1:0] chars_high = '0;

  text_char_t pending_chars[$];
  text_char_t want;
  int         mismatch_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_request = 0;
  int         hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #16_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [CHAR_W-1:0] table_char(input logic [3:0] d);
    logic [VALUE_W-1:0] word;
    word = d[3] ? chars_high : chars_low;
    word = word >> (8 * d[2:0]);
    return word[CHAR_W-1:0];
  endfunction

  // Works out the characters of one number and queues them in order.
  function automatic void predict_text(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] base;
    logic [3:0]         digits[$];
    logic               neg;
    int                 room;
    int                 total;
    int                 count;
    text_char_t         c;
    neg = value[VALUE_W-1];
    mag = value;
    if (neg) begin
      if (mag == MIN_VALUE) mag = mag + 1;
      mag = ~mag + 1;
    end
    if (radix_reg < 2) base = VALUE_W'(2);
    else if (radix_reg > MAX_RADIX) base = VALUE_W'(MAX_RADIX);
    else base = VALUE_W'(radix_reg);
    room = MAX_DIGITS - int'(neg);
    do begin
      if (digits.size() < room) digits.push_back(4'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    total = digits.size() + int'(neg);
    count = 0;
    if (neg) begin
      count++;
      c.character  = MINUS_CHAR;
      c.is_last    = (count == total);
      c.char_count = CNT_W'(count);
      pending_chars.push_back(c);
    end
    for (int k = digits.size() - 1; k >= 0; k--) begin
      count++;
      c.character  = table_char(digits[k]);
      c.is_last    = (count == total);
      c.char_count = CNT_W'(count);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    int unsigned        w;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = MIN_VALUE;
          2: v = MAX_VALUE;
          3: v = '1;
          default: v = 64'd1;
        endcase
      end
      1, 2: ;
      default: begin
        w = $urandom_range(1, VALUE_W - 1);
        v = v & ((64'd1 << w) - 1);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic send_value(input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      din_if.valid <= 1'b0;
      @(posedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.value <= value;
    do @(posedge clk); while (!din_if.ready);
    predict_text(value);
  endtask

  task automatic wait_for_text();
    din_if.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_RADIX:       radix_reg = data[RADIX_W-1:0];
      REG_DIGITS_LOW:  chars_low = data;
      REG_DIGITS_HIGH: chars_high = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [RADIX_W-1:0] radix, input logic [VALUE_W-1:0] low,
                            input logic [VALUE_W-1:0] high);
    logic [VALUE_W-1:0] data;
    // Upper bits of the radix word are noise that the block must drop.
    data = {$urandom, $urandom};
    data[RADIX_W-1:0] = radix;
    write_reg(REG_RADIX, data);
    write_reg(REG_DIGITS_LOW, low);
    write_reg(REG_DIGITS_HIGH, high);
  endtask

  task automatic test_reset_defaults();
    // Tables are still zero, so every digit comes out as a zero byte.
    send_value(64'd0);
    send_value(64'd1);
    send_value('1);
    send_value(64'd1234567890);
    send_value(MAX_VALUE);
    send_value(MIN_VALUE);
    wait_for_text();
  endtask

  task automatic test_digit_tables();
    set_config(RADIX_W'(16), ASCII_LOW, ASCII_HIGH);
    send_value(64'h0123_4567_89AB_CDEF);
    send_value(64'hFEDC_BA98_7654_3210);
    send_value(64'd0);
    wait_for_text();
    set_config(RADIX_W'(16), '1, '1);
    send_value(64'h0FED_CBA9);
    wait_for_text();
    set_config(RADIX_W'(16), {$urandom, $urandom}, {$urandom, $urandom});
    send_value(64'hFEDC_BA98_7654_3210);
    send_value(64'h0123_4567_89AB_CDEF);
    wait_for_text();
  endtask

  task automatic test_radix_extremes();
    set_config(RADIX_W'(2), ASCII_LOW, ASCII_HIGH);
    send_value(MAX_VALUE);
    send_value(MIN_VALUE);
    send_value('1);
    wait_for_text();
    set_config(RADIX_W'(16), ASCII_LOW, ASCII_HIGH);
    send_value(MIN_VALUE);
    send_value(MAX_VALUE);
    wait_for_text();
    // Out-of-range bases are clamped to two and sixteen, and upper bits of the radix word are dropped.
    write_reg(REG_RADIX, 64'd0);
    send_value(64'd5);
    wait_for_text();
    write_reg(REG_RADIX, 64'd1);
    send_value(-64'sd6);
    wait_for_text();
    write_reg(REG_RADIX, 64'd17);
    send_value(64'd255);
    wait_for_text();
    write_reg(REG_RADIX, 64'd31);
    send_value(-64'sd256);
    wait_for_text();
    write_reg(REG_RADIX, 64'hFFFF_FFFF_FFFF_FFE3);
    send_value(64'd100);
    wait_for_text();
    // A write to an index beyond the register list must change nothing.
    write_reg(REG_UNUSED, 64'd2);
    send_value(64'd100);
    wait_for_text();
  endtask

  task automatic test_random_traffic();
    logic [RADIX_W-1:0] radix;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 27; recv_idle_pct = 69; end
        1: begin send_idle_pct = 69; recv_idle_pct = 27; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int setting = 0; setting < 3; setting++) begin
        if ($urandom_range(3) == 0) radix = RADIX_W'($urandom_range(0, 31));
        else radix = RADIX_W'($urandom_range(2, MAX_RADIX));
        if ($urandom_range(1)) set_config(radix, ASCII_LOW, ASCII_HIGH);
        else set_config(radix, {$urandom, $urandom}, {$urandom, $urandom});
        for (int n = 0; n < 12; n++) send_value(random_value());
        wait_for_text();
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(RADIX_W'(10), ASCII_LOW, ASCII_HIGH);
    // The sink stops for a long while; the input must back up and stall.
    hold_request = 3000;
    for (int n = 0; n < 5; n++) send_value({$urandom, $urandom});
    wait_for_text();
    for (int n = 0; n < 3; n++) send_value(random_value());
    wait_for_text();
  endtask

  // Sink side: random stalls, with an occasional long hold-off on request.
  initial begin
    dout_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        dout_if.ready <= 1'b0;
        hold_left--;
      end else begin
        dout_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character transfer: %h", dout_if.character);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (dout_if.character !== want.character) begin
          $error("character: expected %h, got %h", want.character, dout_if.character);
          mismatch_count++;
        end
        if (dout_if.is_last !== want.is_last) begin
          $error("is_last: expected %b, got %b", want.is_last, dout_if.is_last);
          mismatch_count++;
        end
        if (dout_if.char_count !== want.char_count) begin
          $error("char_count: expected %0d, got %0d", want.char_count, dout_if.char_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    din_if.valid <= 1'b0;
    din_if.value <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_RADIX;
    cfg_if.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_digit_tables();
    test_radix_extremes();
    test_random_traffic();
    test_backpressure();
    wait_for_text();
    // Long enough for the slowest number to reach the output, should a stray one appear.
    repeat (4200) @(posedge clk);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/srta_pkg.sv
hdl/srta_in_if.sv
hdl/srta_out_if.sv
hdl/srta_cfg_if.sv
hdl/srta_digit_gen.sv
hdl/signed_radix_to_ascii.sv
tb/tb_signed_radix_to_ascii.sv
